// ----- rtl/lfu_pkg.sv -----
// package: shared types and constants for the lfu cache replacement block
package lfu_pkg;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [0:0]       REG_CAPACITY  = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET     = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] key;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } resp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_UPDATE
  } state_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_TOUCH,
    UPD_INSERT
  } upd_op_t;

endpackage

// ----- rtl/lfu_cache_replacement.sv -----
// top level: lfu cache with lru tie break, cell chain, controller and apb register
//
// channel   direction  handshake                         payload
// request   in         start & !busy                     req (cmd, key, write_value)
// result    out        done, one cycle, no back-pressure resp (hit, read_value, evicted,
//                                                        evicted_key)
// config    in         psel & penable & pwrite & pready  pwdata[4:0] at paddr 0-3
//
// an item runs from accept through the sweep and update states: the search token walks
// the cell chain one cell per cycle, then the update state applies the change to the cells,
// and the result beat shows in the cycle after, when the next request may already enter.
// reset clears all valid bits and the fill level and sets capacity to 16.
// results cannot be stalled; busy holds off requests while an item is in flight.
module lfu_cache_replacement
  import lfu_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               req,
  output logic               done,
  output resp_t              resp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int TOK_W  = IDX_W * 5 + 99;

  typedef struct packed {
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_rank;
    logic [31:0]      hit_value;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             vic_have;
    logic [IDX_W-1:0] vic_idx;
    logic [31:0]      vic_count;
    logic [31:0]      vic_key;
  } tok_t;

  typedef struct packed {
    upd_op_t          op;
    logic [IDX_W-1:0] tgt_idx;
    logic [IDX_W-1:0] ref_rank;
    logic             write_value_en;
    logic             evict;
    logic [IDX_W-1:0] vic_idx;
    logic [IDX_W-1:0] vic_rank;
    logic [31:0]      key;
    logic [31:0]      value;
  } upd_t;

  state_t state, state_next;

  logic [CAP_W-1:0]  cap;
  logic [FILL_W-1:0] fill, fill_next;
  logic [FILL_W-1:0] cap_eff;
  logic [IDX_W-1:0]  cnt;
  req_t              req_q;
  resp_t             resp_next;
  logic              accept;
  logic              cfg_wr;
  logic              full;
  logic              evict;
  logic [IDX_W-1:0]  slot;
  tok_t              fin;
  logic [IDX_W-1:0]  fin_vic_rank;
  upd_t              upd;

  logic [TOK_W-1:0]  tok [ENTRIES+1];

  assign pready = 1'b1;
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == REG_CAPACITY);
  assign prdata = (paddr[2:2] == REG_CAPACITY) ? PDATA_W'(cap) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_wr) begin
      cap <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    if (cap == '0) begin
      cap_eff = FILL_W'(1);
    end else if (32'(cap) > 32'(ENTRIES)) begin
      cap_eff = FILL_W'(ENTRIES);
    end else begin
      cap_eff = FILL_W'(cap);
    end
  end

  assign tok[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .ENTRIES (ENTRIES),
      .MY_IDX  (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .search_key (req_q.key),
      .tok_in     (tok[g]),
      .tok_out    (tok[g+1]),
      .upd_in     (upd)
    );
  end

  assign fin          = tok_t'(tok[ENTRIES][$bits(tok_t)-1:0]);
  assign fin_vic_rank = tok[ENTRIES][$bits(tok_t) +: IDX_W];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SWEEP;
      ST_SWEEP:  if (cnt == IDX_W'(ENTRIES - 1)) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign full  = (fill >= cap_eff) || (fill >= FILL_W'(ENTRIES));
  assign evict = (req_q.cmd == CMD_PUT) && !fin.hit_found && full && fin.vic_have;

  always_comb begin
    if (evict) begin
      slot = (fin.free_found && (fin.free_idx < fin.vic_idx)) ? fin.free_idx : fin.vic_idx;
    end else begin
      slot = fin.free_idx;
    end
  end

  always_comb begin
    upd                = '0;
    upd.op             = UPD_NONE;
    fill_next          = fill;
    resp_next          = '0;
    upd.tgt_idx        = fin.hit_found ? fin.hit_idx : slot;
    upd.ref_rank       = fin.hit_rank;
    upd.write_value_en = (req_q.cmd == CMD_PUT);
    upd.evict          = evict;
    upd.vic_idx        = fin.vic_idx;
    upd.vic_rank       = fin_vic_rank;
    upd.key            = req_q.key;
    upd.value          = req_q.write_value;
    resp_next.hit      = fin.hit_found;
    if (req_q.cmd == CMD_GET) begin
      resp_next.read_value = fin.hit_found ? fin.hit_value : READ_MISS;
    end
    resp_next.evicted     = evict;
    resp_next.evicted_key = evict ? fin.vic_key : 32'd0;
    if (state == ST_UPDATE) begin
      if (fin.hit_found) begin
        upd.op = UPD_TOUCH;
      end else if (req_q.cmd == CMD_PUT) begin
        upd.op = UPD_INSERT;
        if (!evict) fill_next = fill + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= (state == ST_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      cnt   <= '0;
    end else if (state == ST_SWEEP) begin
      cnt <= cnt + IDX_W'(1);
    end
    if (state == ST_UPDATE) resp <= resp_next;
  end

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("result beat without an update cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(ENTRIES))
    else $error("fill level above entry count");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    (done && resp.evicted) |-> !resp.hit)
    else $error("eviction reported on a hit");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not raise busy");

endmodule

// ----- rtl/lfu_cell.sv -----
// cell: one cache entry, merges its entry into the search token and applies updates
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int MY_IDX  = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] search_key,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)*5+99-1:0] tok_in,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)*5+99-1:0] tok_out,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)*4+66+2-1:0] upd_in
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] ME = IDX_W'(MY_IDX);

  typedef struct packed {
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_rank;
    logic [31:0]      hit_value;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             vic_have;
    logic [IDX_W-1:0] vic_idx;
    logic [31:0]      vic_count;
    logic [31:0]      vic_key;
  } tok_t;

  typedef struct packed {
    upd_op_t          op;
    logic [IDX_W-1:0] tgt_idx;
    logic [IDX_W-1:0] ref_rank;
    logic             write_value_en;
    logic             evict;
    logic [IDX_W-1:0] vic_idx;
    logic [IDX_W-1:0] vic_rank;
    logic [31:0]      key;
    logic [31:0]      value;
  } upd_t;

  tok_t tin, tmerge, tok;
  upd_t upd;

  logic             valid, valid_next;
  logic [31:0]      key, key_next;
  logic [31:0]      value, value_next;
  logic [31:0]      count, count_next;
  logic [IDX_W-1:0] rank, rank_next;
  logic [IDX_W-1:0] vic_rank_tok;
  logic [IDX_W-1:0] vic_rank_q;
  logic [IDX_W-1:0] vic_rank_in;
  logic             vkeep;
  logic [IDX_W-1:0] rank_adj;

  assign tin = tok_t'(tok_in[$bits(tok_t)-1:0]);
  assign vic_rank_in = tok_in[$bits(tok_t) +: IDX_W];
  assign upd = upd_t'(upd_in[$bits(upd_t)-1:0]);

  // search token: first hit, first free slot, lfu victim with lru tie break
  always_comb begin
    tmerge = tin;
    vic_rank_tok = vic_rank_in;
    if (!tin.hit_found && valid && (key == search_key)) begin
      tmerge.hit_found = 1'b1;
      tmerge.hit_idx   = ME;
      tmerge.hit_rank  = rank;
      tmerge.hit_value = value;
    end
    if (!tin.free_found && !valid) begin
      tmerge.free_found = 1'b1;
      tmerge.free_idx   = ME;
    end
    if (valid && (!tin.vic_have || (count < tin.vic_count) ||
        ((count == tin.vic_count) && (rank > vic_rank_in)))) begin
      tmerge.vic_have  = 1'b1;
      tmerge.vic_idx   = ME;
      tmerge.vic_count = count;
      tmerge.vic_key   = key;
      vic_rank_tok     = rank;
    end
  end

  always_ff @(posedge clk) begin
    tok        <= tmerge;
    vic_rank_q <= vic_rank_tok;
  end

  assign tok_out = {vic_rank_q, tok};

  assign vkeep    = valid && !(upd.evict && (upd.vic_idx == ME));
  assign rank_adj = (upd.evict && (rank > upd.vic_rank)) ? (rank - IDX_W'(1)) : rank;

  always_comb begin
    valid_next = valid;
    key_next   = key;
    value_next = value;
    count_next = count;
    rank_next  = rank;
    unique case (upd.op)
      UPD_TOUCH: begin
        if (upd.tgt_idx == ME) begin
          rank_next = '0;
          if (count != '1) count_next = count + 32'd1;
          if (upd.write_value_en) value_next = upd.value;
        end else if (valid && (rank < upd.ref_rank)) begin
          rank_next = rank + IDX_W'(1);
        end
      end
      UPD_INSERT: begin
        if (upd.tgt_idx == ME) begin
          valid_next = 1'b1;
          key_next   = upd.key;
          value_next = upd.value;
          count_next = 32'd1;
          rank_next  = '0;
        end else begin
          valid_next = vkeep;
          if (vkeep) rank_next = rank_adj + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    value <= value_next;
    count <= count_next;
    rank  <= rank_next;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// testbench for lfu_cache_replacement: random get/put traffic checked against an inline cache predictor
module tb;
  import lfu_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 24;
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = PADDR_W'(4 * int'(REG_CAPACITY));
  localparam logic [PADDR_W-1:0] ADDR_SPARE    = PADDR_W'(4 * (int'(REG_CAPACITY) + 1));

  logic               clk;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  logic               busy;
  req_t               req     = '0;
  logic               done;
  resp_t              resp;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lfu_cache_replacement #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .resp   (resp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predicted cache contents
  logic        ent_valid [ENTRIES];
  logic [31:0] ent_key   [ENTRIES];
  logic [31:0] ent_value [ENTRIES];
  logic [31:0] ent_count [ENTRIES];
  int          ent_rank  [ENTRIES];
  int          fill_count;
  logic [4:0]  cap_reg;

  req_t        pending_req[$];
  resp_t       expected_resp[$];
  resp_t       want;
  logic [31:0] key_pool [POOL_SIZE];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          gap_left       = 0;
  bit          no_gaps        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void touch_entry(int idx);
    int j;
    int r;
    r = ent_rank[idx];
    if (ent_count[idx] != 32'hFFFF_FFFF) ent_count[idx] = ent_count[idx] + 32'd1;
    for (j = 0; j < ENTRIES; j++)
      if (ent_valid[j] && ent_rank[j] < r) ent_rank[j]++;
    ent_rank[idx] = 0;
  endfunction

  function automatic resp_t serve_request(req_t r);
    resp_t o;
    int    i;
    int    found;
    int    victim;
    int    slot;
    int    cap;
    int    vr;
    o     = '0;
    found = -1;
    for (i = 0; i < ENTRIES; i++)
      if (found < 0 && ent_valid[i] && ent_key[i] == r.key) found = i;
    o.hit = (found >= 0);
    if (r.cmd == CMD_GET) begin
      if (found >= 0) begin
        o.read_value = ent_value[found];
        touch_entry(found);
      end else begin
        o.read_value = READ_MISS;
      end
    end else if (found >= 0) begin
      ent_value[found] = r.write_value;
      touch_entry(found);
    end else begin
      cap = int'(cap_reg);
      if (cap == 0) cap = 1;
      if (cap > ENTRIES) cap = ENTRIES;
      if (fill_count >= cap) begin
        victim = -1;
        for (i = 0; i < ENTRIES; i++)
          if (ent_valid[i] && (victim < 0 || ent_count[i] < ent_count[victim] ||
              (ent_count[i] == ent_count[victim] && ent_rank[i] > ent_rank[victim])))
            victim = i;
        if (victim >= 0) begin
          vr = ent_rank[victim];
          ent_valid[victim] = 1'b0;
          for (i = 0; i < ENTRIES; i++)
            if (ent_valid[i] && ent_rank[i] > vr) ent_rank[i]--;
          o.evicted     = 1'b1;
          o.evicted_key = ent_key[victim];
          if (fill_count > 0) fill_count--;
        end
      end
      slot = 0;
      for (i = ENTRIES - 1; i >= 0; i--)
        if (!ent_valid[i]) slot = i;
      for (i = 0; i < ENTRIES; i++)
        if (ent_valid[i]) ent_rank[i]++;
      ent_valid[slot] = 1'b1;
      ent_key[slot]   = r.key;
      ent_value[slot] = r.write_value;
      ent_count[slot] = 32'd1;
      ent_rank[slot]  = 0;
      fill_count++;
    end
    return o;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_resp.push_back(serve_request(pending_req.pop_front()));
      if (!start || !busy) begin
        if (gap_left == 0 && !no_gaps && $urandom_range(0, 99) < 8)
          gap_left = $urandom_range(1, 24);
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_req.size() != 0) begin
          start <= 1'b1;
          req   <= pending_req[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_resp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: hit=%0d read=%h evicted=%0d evkey=%h",
                   resp.hit, resp.read_value, resp.evicted, resp.evicted_key);
      end else begin
        want = expected_resp.pop_front();
        if (resp.hit !== want.hit || resp.read_value !== want.read_value ||
            resp.evicted !== want.evicted || resp.evicted_key !== want.evicted_key) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp hit=%0d read=%h ev=%0d evkey=%h, got hit=%0d read=%h ev=%0d evkey=%h",
                     want.hit, want.read_value, want.evicted, want.evicted_key,
                     resp.hit, resp.read_value, resp.evicted, resp.evicted_key);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_request(input logic cmd, input logic [31:0] key, input logic [31:0] value);
    req_t r;
    r.cmd         = cmd;
    r.key         = key;
    r.write_value = value;
    pending_req.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_req.size() != 0 || expected_resp.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [4:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ($urandom() & 32'hFFFF_FFE0) | {27'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_CAPACITY) cap_reg = value;
  endtask

  task automatic queue_random(input int n_items, input int pool_n);
    int          n;
    logic [31:0] k;
    for (n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < 10) k = $urandom();
      else k = key_pool[$urandom_range(0, pool_n - 1)];
      queue_request(($urandom_range(0, 1) == 1) ? CMD_PUT : CMD_GET, k, $urandom());
    end
  endtask

  initial begin
    int p;
    int phase_cap [8];
    int phase_pool [8];
    for (p = 0; p < ENTRIES; p++) begin
      ent_valid[p] = 1'b0;
      ent_key[p]   = '0;
      ent_value[p] = '0;
      ent_count[p] = '0;
      ent_rank[p]  = 0;
    end
    fill_count = 0;
    cap_reg    = CAP_RESET;
    for (p = 0; p < POOL_SIZE; p++) key_pool[p] = $urandom();
    phase_cap  = '{2, 5, 9, 12, 31, 4, 16, 1};
    phase_pool = '{5, 8, 13, 16, 22, 20, 20, 18};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // spare address must be ignored
    apb_write(ADDR_SPARE, 5'd7);
    apb_write(ADDR_CAPACITY, 5'd1);
    queue_request(CMD_GET, 32'h0000_0000, 32'h1234_5678);
    queue_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_request(CMD_PUT, 32'h8000_0000, 32'h0000_0000);
    queue_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_idle();

    apb_write(ADDR_CAPACITY, 5'd3);
    queue_request(CMD_PUT, 32'd1, 32'd1);
    queue_request(CMD_PUT, 32'd2, 32'd2);
    queue_request(CMD_GET, 32'd1, 32'd0);
    queue_request(CMD_GET, 32'hFFFF_FFFF, 32'd0);
    queue_request(CMD_PUT, 32'd4, 32'd4);
    queue_request(CMD_PUT, 32'd5, 32'd5);
    queue_request(CMD_GET, 32'd2, 32'd0);
    queue_request(CMD_GET, 32'd1, 32'd0);
    queue_request(CMD_PUT, 32'd6, 32'd6);
    queue_request(CMD_GET, 32'd0, 32'd0);
    wait_idle();

    for (p = 0; p < 8; p++) begin
      apb_write(ADDR_CAPACITY, phase_cap[p][4:0]);
      no_gaps = (p == 2);
      queue_random(50, phase_pool[p]);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
